### src/kpl_pkg.sv
`timescale 1ns / 1ps

package kpl_pkg;

	// Sizes of the user table and of one code entry.
	localparam int USER_SLOTS  = 16;
	localparam int CODE_DIGITS = 4;
	localparam int SLOT_W      = $clog2(USER_SLOTS);
	localparam int CODE_W      = 14;
	localparam int DIG_W       = 3;
	localparam int FAIL_W      = 3;
	localparam int KEY_W       = 4;
	localparam int IDX_W       = 4;
	localparam int EV_W        = 3;
	localparam int PH_W        = 2;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int ATT_W   = 3;
	localparam logic [ATT_W-1:0] ATT_RESET = 3'd3;

	// Register index of the attempt limit.
	localparam logic REG_MAX_ATTEMPTS = 1'b0;

	// Reciprocal of ten for 16-bit operands: x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT.
	localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
	localparam int          DIV10_SHIFT = 19;
	localparam int          DIV10_PW    = CODE_W + 16;

	// Item kinds.
	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	// Special keys.
	localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd10;
	localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;

	typedef enum logic [PH_W-1:0] {
		PH_ID   = 2'd0,
		PH_PASS = 2'd1,
		PH_LOCK = 2'd2
	} phase_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE  = 3'd0,
		EV_EDIT  = 3'd1,
		EV_BADID = 3'd2,
		EV_BADPW = 3'd3,
		EV_OK    = 3'd4,
		EV_ALARM = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_PW_RD,
		SQ_PW_CMP,
		SQ_EMIT
	} seq_t;

	// Table write request.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [CODE_W-1:0] id;
		logic [CODE_W-1:0] pw;
	} tbl_wr_t;

	// Table read data.
	typedef struct packed {
		logic [CODE_W-1:0] id;
		logic [CODE_W-1:0] pw;
	} tbl_rd_t;

endpackage

### src/kpl_if.sv
`timescale 1ns / 1ps

// Input channel: one key press or one table load per word.
interface kpl_in_if import kpl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [KEY_W-1:0]  key_code;
	logic [IDX_W-1:0]  entry_index;
	logic [CODE_W-1:0] entry_id;
	logic [CODE_W-1:0] entry_password;

	modport source (
		output valid, action, key_code, entry_index, entry_id, entry_password,
		input  ready
	);
	modport sink (
		input  valid, action, key_code, entry_index, entry_id, entry_password,
		output ready
	);
endinterface

// Output channel: one status word per accepted input word.
interface kpl_out_if import kpl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic [PH_W-1:0]   phase;
	logic [DIG_W-1:0]  digits_entered;
	logic [IDX_W-1:0]  user_index;
	logic [FAIL_W-1:0] attempts_used;

	modport source (
		output valid, event_res, phase, digits_entered, user_index, attempts_used,
		input  ready
	);
	modport sink (
		input  valid, event_res, phase, digits_entered, user_index, attempts_used,
		output ready
	);
endinterface

### src/kpl_user_table.sv
`timescale 1ns / 1ps

module kpl_user_table import kpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbl_wr_t               wr,
	input  logic [SLOT_W-1:0]     rd_addr,
	output tbl_rd_t               rd,
	output logic [USER_SLOTS-1:0] vld
);

	tbl_rd_t                mem [USER_SLOTS];
	tbl_rd_t                rd_q;
	logic [USER_SLOTS-1:0]  vld_q;

	// Table storage with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= '{id: wr.id, pw: wr.pw};
		end
		rd_q <= mem[rd_addr];
	end

	// A slot becomes valid on its first load and stays valid until reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd  = rd_q;
	assign vld = vld_q;

endmodule

### src/keypad_user_login_lock_core.sv
// A load or a plain key word passes through the EMIT state into the output register after acceptance.
// A fourth ID digit runs a table scan, one slot per cycle, over up to USER_SLOTS slots.
// A fourth password digit reads the matched slot once (SQ_PW_RD, then SQ_PW_CMP).
// One word at a time: the next word is taken only once the sequencer is back in idle, and the
// status word waits in SQ_EMIT while the previous one is still held by the sink.
// Reset: asynchronous, clears the sequencer, entry and valid bits and sets the attempt limit to 3.
`timescale 1ns / 1ps

module keypad_user_login_lock_core import kpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	kpl_in_if.sink             in_ch,
	kpl_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	seq_t                  state_q, state_d;
	phase_t                mode_q;
	event_t                ev_q;
	logic [CODE_W-1:0]     code_q;
	logic [DIG_W-1:0]      digits_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [FAIL_W-1:0]     fail_q;
	logic [ATT_W-1:0]      max_att_q;
	logic [SLOT_W-1:0]     scan_q;
	logic [SLOT_W-1:0]     probe_idx_q;
	logic                  probe_vld_q;

	logic                  out_vld_q;
	logic [EV_W-1:0]       out_ev_q;
	logic [PH_W-1:0]       out_ph_q;
	logic [DIG_W-1:0]      out_dig_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic [FAIL_W-1:0]     out_fail_q;

	tbl_wr_t               tbl_wr;
	tbl_rd_t               tbl_rd;
	logic [USER_SLOTS-1:0] tbl_vld;
	logic [SLOT_W-1:0]     rd_addr;

	logic                  accept;
	logic                  cfg_wr;
	logic                  emit_go;
	logic                  is_digit;
	logic [DIG_W-1:0]      digits_inc;
	logic                  entry_full;
	logic [CODE_W-1:0]     code_times10;
	logic [DIV10_PW-1:0]   div10_prod;
	logic [CODE_W-1:0]     code_div10;
	logic                  scan_hit;
	logic                  scan_last;
	logic                  pw_ok;
	logic [FAIL_W-1:0]     fail_inc;

	// Configuration register: the attempt limit.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ATTEMPTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= ATT_RESET;
		end else if (cfg_wr) begin
			max_att_q <= pwdata[ATT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_ATTEMPTS) ? PDATA_W'(max_att_q) : '0;

	// Entry arithmetic: append a digit, or drop the last one.
	assign accept       = in_ch.valid && in_ch.ready;
	assign is_digit     = (in_ch.key_code <= KEY_DIGIT_MAX);
	assign digits_inc   = digits_q + DIG_W'(1);
	assign entry_full   = (digits_inc >= DIG_W'(CODE_DIGITS));
	assign code_times10 = (code_q << 3) + (code_q << 1) + CODE_W'(in_ch.key_code);
	assign div10_prod   = DIV10_PW'(code_q) * DIV10_PW'(DIV10_MUL);
	assign code_div10   = CODE_W'(div10_prod >> DIV10_SHIFT);

	// Compare terms: ID match during the scan, password match afterwards.
	assign scan_hit  = probe_vld_q && tbl_vld[probe_idx_q] && (tbl_rd.id == code_q);
	assign scan_last = probe_vld_q && (probe_idx_q == SLOT_W'(USER_SLOTS - 1));
	assign pw_ok     = tbl_vld[slot_q] && (tbl_rd.pw == code_q);
	assign fail_inc  = (fail_q < FAIL_W'(7)) ? fail_q + FAIL_W'(1) : fail_q;

	assign rd_addr = (state_q == SQ_SCAN) ? scan_q : slot_q;

	// Table loads go straight to the write port.
	assign tbl_wr.en   = accept && (in_ch.action == ACT_LOAD);
	assign tbl_wr.addr = SLOT_W'(in_ch.entry_index);
	assign tbl_wr.id   = in_ch.entry_id;
	assign tbl_wr.pw   = in_ch.entry_password;

	kpl_user_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd      (tbl_rd),
		.vld     (tbl_vld)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake.
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		emit_go     = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = SQ_EMIT;
					if (in_ch.action == ACT_KEY && mode_q != PH_LOCK && is_digit
							&& entry_full) begin
						state_d = (mode_q == PH_ID) ? SQ_SCAN : SQ_PW_RD;
					end
				end
			end
			SQ_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = SQ_EMIT;
				end
			end
			SQ_PW_RD: begin
				state_d = SQ_PW_CMP;
			end
			SQ_PW_CMP: begin
				state_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				emit_go = !out_vld_q || out_ch.ready;
				if (emit_go) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// Entry, phase and attempt state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= PH_ID;
			ev_q        <= EV_NONE;
			code_q      <= '0;
			digits_q    <= '0;
			slot_q      <= '0;
			fail_q      <= '0;
			scan_q      <= '0;
			probe_idx_q <= '0;
			probe_vld_q <= 1'b0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						ev_q <= EV_NONE;
						if (in_ch.action == ACT_KEY && mode_q != PH_LOCK) begin
							if (is_digit) begin
								code_q      <= code_times10;
								ev_q        <= EV_EDIT;
								digits_q    <= entry_full ? '0 : digits_inc;
								scan_q      <= '0;
								probe_vld_q <= 1'b0;
							end else if (in_ch.key_code == KEY_CLEAR) begin
								code_q   <= '0;
								digits_q <= '0;
								ev_q     <= EV_EDIT;
							end else if (in_ch.key_code == KEY_BACK) begin
								if (digits_q != '0) begin
									code_q   <= code_div10;
									digits_q <= digits_q - DIG_W'(1);
									ev_q     <= EV_EDIT;
								end
							end
						end
					end
				end
				SQ_SCAN: begin
					if (scan_hit) begin
						slot_q <= probe_idx_q;
						mode_q <= PH_PASS;
						fail_q <= '0;
						ev_q   <= EV_EDIT;
						code_q <= '0;
					end else if (scan_last) begin
						ev_q   <= EV_BADID;
						code_q <= '0;
					end else begin
						probe_idx_q <= scan_q;
						probe_vld_q <= 1'b1;
						scan_q      <= scan_q + SLOT_W'(1);
					end
				end
				SQ_PW_CMP: begin
					code_q <= '0;
					if (pw_ok) begin
						mode_q <= PH_ID;
						fail_q <= '0;
						ev_q   <= EV_OK;
					end else begin
						fail_q <= fail_inc;
						if (fail_inc >= max_att_q) begin
							mode_q <= PH_LOCK;
							ev_q   <= EV_ALARM;
						end else begin
							ev_q <= EV_BADPW;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: holds one status word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_ev_q   <= ev_q;
			out_ph_q   <= mode_q;
			out_dig_q  <= digits_q;
			out_idx_q  <= (mode_q == PH_PASS) ? IDX_W'(slot_q) : '0;
			out_fail_q <= fail_q;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.event_res      = out_ev_q;
	assign out_ch.phase          = out_ph_q;
	assign out_ch.digits_entered = out_dig_q;
	assign out_ch.user_index     = out_idx_q;
	assign out_ch.attempts_used  = out_fail_q;

`ifndef SYNTHESIS
	// The locked phase is left only by reset.
	a_lock_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PH_LOCK |=> mode_q == PH_LOCK)
		else $error("locked phase was left");

	// An alarm word always reports the locked phase.
	a_alarm_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.event_res == EV_ALARM |-> out_ch.phase == PH_LOCK)
		else $error("alarm word outside locked phase");

	// The password phase always points at a loaded slot.
	a_pass_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PH_PASS |-> tbl_vld[slot_q])
		else $error("password phase on an empty slot");

	// A complete entry never stays in the digit counter.
	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q < DIG_W'(CODE_DIGITS))
		else $error("digit counter overflow");
`endif

endmodule
